FILE: hw/rtl/cmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock multiplier/divider package
// Shared widths, register indexes and the control bundle between the edge
// timer and the phase generators.
// ----------------------------------------------------------------------------
package cmd_pkg;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned ElapsedWidth = 16;
  localparam int unsigned ShiftWidth   = 2;

  localparam logic [CfgIdxWidth-1:0] CfgDebounce   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTriggerLen = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgSlowShift  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgFastShift  = 2'd3;

  localparam logic [CfgDataWidth-1:0] DebounceReset   = 16'd2000;
  localparam logic [CfgDataWidth-1:0] TriggerLenReset = 16'd4000;
  localparam logic [ShiftWidth-1:0]   SlowShiftReset  = 2'd1;
  localparam logic [ShiftWidth-1:0]   FastShiftReset  = 2'd2;

  // Edge counter values (edges_q in the edge timer)
  localparam logic [1:0] EdgesNone  = 2'd0;
  localparam logic [1:0] EdgesFirst = 2'd1;
  localparam logic [1:0] EdgesLocked = 2'd2;

  typedef struct packed {
    logic set_period;  // accepted edge: load new period, maybe snap phase
    logic advance;     // step the phase by the elapsed time
  } phase_cmd_t;

endpackage

FILE: hw/rtl/cmd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample stream interface
// Valid/ready channel carrying one clock level sample and its elapsed time.
// ----------------------------------------------------------------------------
interface cmd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                clock_level;
  logic [cmd_pkg::ElapsedWidth-1:0]    elapsed_us;

  modport source (output valid, output clock_level, output elapsed_us, input ready);
  modport sink (input valid, input clock_level, input elapsed_us, output ready);
  modport monitor (input valid, input clock_level, input elapsed_us, input ready);
endinterface

FILE: hw/rtl/cmd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output level stream interface
// Valid/ready channel carrying the trigger, gate and beat levels.
// ----------------------------------------------------------------------------
interface cmd_out_if;
  logic valid;
  logic ready;
  logic trig_a;
  logic gate_a;
  logic trig_b;
  logic gate_b;
  logic beat_flag;

  modport source (output valid, output trig_a, output gate_a, output trig_b,
                  output gate_b, output beat_flag, input ready);
  modport sink (input valid, input trig_a, input gate_a, input trig_b,
                input gate_b, input beat_flag, output ready);
  modport monitor (input valid, input trig_a, input gate_a, input trig_b,
                   input gate_b, input beat_flag, input ready);
endinterface

FILE: hw/rtl/cmd_edge_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge timer
// Saturating time-since-edge counter, debounced rising edge detection,
// beat toggle and derivation of the two output periods.
// ----------------------------------------------------------------------------
module cmd_edge_timer #(
  parameter int unsigned TimeWidth = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 level_i,
  input  logic [cmd_pkg::ElapsedWidth-1:0]     elapsed_i,
  input  logic [cmd_pkg::CfgDataWidth-1:0]     debounce_i,
  input  logic [cmd_pkg::ShiftWidth-1:0]       slow_shift_i,
  input  logic [cmd_pkg::ShiftWidth-1:0]       fast_shift_i,
  output cmd_pkg::phase_cmd_t                  cmd_o,
  output logic [TimeWidth-1:0]                 period_a_o,
  output logic [TimeWidth-1:0]                 period_b_o,
  output logic                                 beat_o
);

  localparam int unsigned ShiftMax = (1 << cmd_pkg::ShiftWidth) - 1;

  logic                 prev_q, prev_d;
  logic [1:0]           edges_q, edges_d;
  logic [TimeWidth-1:0] since_q, since_d;
  logic                 beat_q, beat_d;

  logic [TimeWidth:0]          since_sum;
  logic [TimeWidth-1:0]        since_sat;
  logic [TimeWidth+ShiftMax-1:0] slow_wide;
  logic                        rise, first_edge, acc_edge;

  always_comb begin
    since_sum = {1'b0, since_q} + (TimeWidth + 1)'(elapsed_i);
    since_sat = since_sum[TimeWidth] ? '1 : since_sum[TimeWidth-1:0];

    rise       = !prev_q && level_i;
    first_edge = rise && (edges_q == cmd_pkg::EdgesNone);
    acc_edge   = rise && (edges_q != cmd_pkg::EdgesNone)
                 && (since_sat > TimeWidth'(debounce_i));

    prev_d  = level_i;
    since_d = (first_edge || acc_edge) ? '0 : since_sat;
    beat_d  = beat_q ^ acc_edge;
    edges_d = edges_q;
    if (first_edge) begin
      edges_d = cmd_pkg::EdgesFirst;
    end else if (acc_edge && edges_q == cmd_pkg::EdgesFirst) begin
      edges_d = cmd_pkg::EdgesLocked;
    end

    // output A period saturates on overflow of the left shift
    slow_wide  = (TimeWidth + ShiftMax)'(since_sat) << slow_shift_i;
    period_a_o = (slow_wide[TimeWidth+ShiftMax-1:TimeWidth] != '0) ? '1
                 : slow_wide[TimeWidth-1:0];
    period_b_o = since_sat >> fast_shift_i;

    cmd_o.set_period = acc_edge;
    cmd_o.advance    = (edges_d == cmd_pkg::EdgesLocked) && (elapsed_i != '0);
  end

  assign beat_o = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      edges_q <= cmd_pkg::EdgesNone;
      since_q <= '0;
      beat_q  <= 1'b0;
    end else if (en_i) begin
      prev_q  <= prev_d;
      edges_q <= edges_d;
      since_q <= since_d;
      beat_q  <= beat_d;
    end
  end

endmodule

FILE: hw/rtl/cmd_phase_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase generator
// One output channel: period and phase registers, phase snap on a new period,
// single-subtract wrap, and the held trigger/gate levels.
// ----------------------------------------------------------------------------
module cmd_phase_gen #(
  parameter int unsigned TimeWidth = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  cmd_pkg::phase_cmd_t              cmd_i,
  input  logic [TimeWidth-1:0]             new_period_i,
  input  logic [cmd_pkg::ElapsedWidth-1:0] elapsed_i,
  input  logic [cmd_pkg::CfgDataWidth-1:0] trig_len_i,
  output logic                             trig_o,
  output logic                             gate_o
);

  logic [TimeWidth-1:0] period_q, period_d;
  logic [TimeWidth-1:0] phase_q, phase_d;
  logic                 trig_q, trig_d;
  logic                 gate_q, gate_d;

  logic [TimeWidth-1:0] tol, phase_sel, phase_nx;
  logic [TimeWidth:0]   sum, wrapped;

  always_comb begin
    tol      = new_period_i >> 3;
    period_d = cmd_i.set_period ? new_period_i : period_q;

    // snap to zero when within an eighth of the new period from either end
    phase_sel = phase_q;
    if (cmd_i.set_period && (phase_q < tol || phase_q > new_period_i - tol)) begin
      phase_sel = '0;
    end

    sum      = {1'b0, phase_sel} + (TimeWidth + 1)'(elapsed_i);
    wrapped  = (sum >= {1'b0, period_d}) ? sum - {1'b0, period_d} : sum;
    phase_nx = wrapped[TimeWidth] ? '1 : wrapped[TimeWidth-1:0];

    phase_d = phase_sel;
    trig_d  = trig_q;
    gate_d  = gate_q;
    if (cmd_i.advance) begin
      phase_d = phase_nx;
      trig_d  = phase_nx < TimeWidth'(trig_len_i);
      gate_d  = phase_nx < (period_d >> 1);
    end
  end

  assign trig_o = trig_q;
  assign gate_o = gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '1;
      phase_q  <= '0;
      trig_q   <= 1'b0;
      gate_q   <= 1'b0;
    end else if (en_i) begin
      period_q <= period_d;
      phase_q  <= phase_d;
      trig_q   <= trig_d;
      gate_q   <= gate_d;
    end
  end

endmodule

FILE: hw/rtl/clock_multiplier_divider_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock multiplier/divider core
// Measures the period of a sampled clock input and produces a slower and a
// faster output, each with a trigger pulse and a 50% gate, plus a beat flag.
// ----------------------------------------------------------------------------
// Throughput is one sample transaction per clock, the result following in the next cycle:
// all per-sample work (counter add, edge/debounce compare, period shifts,
// phase add and single-subtract wrap) settles between the state registers and
// the result register, and a new sample is taken whenever the result register
// is empty or being drained in the same cycle. TIME_WIDTH sets the width of
// the interval counter, periods and phases. Configuration writes are
// expected while no transaction is in flight.
// ----------------------------------------------------------------------------
module clock_multiplier_divider_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cmd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [cmd_pkg::CfgDataWidth-1:0]  cfg_wdata_i,
  cmd_in_if.sink                            item_i,
  cmd_out_if.source                         result_o
);

  logic [cmd_pkg::CfgDataWidth-1:0] debounce_q, trig_len_q;
  logic [cmd_pkg::ShiftWidth-1:0]   slow_shift_q, fast_shift_q;
  logic                             out_valid_q, out_valid_d;
  logic                             accept;

  cmd_pkg::phase_cmd_t    cmd;
  logic [TIME_WIDTH-1:0]  period_a, period_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= cmd_pkg::DebounceReset;
      trig_len_q   <= cmd_pkg::TriggerLenReset;
      slow_shift_q <= cmd_pkg::SlowShiftReset;
      fast_shift_q <= cmd_pkg::FastShiftReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmd_pkg::CfgDebounce:   debounce_q   <= cfg_wdata_i;
        cmd_pkg::CfgTriggerLen: trig_len_q   <= cfg_wdata_i;
        cmd_pkg::CfgSlowShift:  slow_shift_q <= cfg_wdata_i[cmd_pkg::ShiftWidth-1:0];
        cmd_pkg::CfgFastShift:  fast_shift_q <= cfg_wdata_i[cmd_pkg::ShiftWidth-1:0];
        default: ;
      endcase
    end
  end

  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid = out_valid_q;

  cmd_edge_timer #(
    .TimeWidth (TIME_WIDTH)
  ) u_edge_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .level_i      (item_i.clock_level),
    .elapsed_i    (item_i.elapsed_us),
    .debounce_i   (debounce_q),
    .slow_shift_i (slow_shift_q),
    .fast_shift_i (fast_shift_q),
    .cmd_o        (cmd),
    .period_a_o   (period_a),
    .period_b_o   (period_b),
    .beat_o       (result_o.beat_flag)
  );

  cmd_phase_gen #(
    .TimeWidth (TIME_WIDTH)
  ) u_phase_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .cmd_i        (cmd),
    .new_period_i (period_a),
    .elapsed_i    (item_i.elapsed_us),
    .trig_len_i   (trig_len_q),
    .trig_o       (result_o.trig_a),
    .gate_o       (result_o.gate_a)
  );

  cmd_phase_gen #(
    .TimeWidth (TIME_WIDTH)
  ) u_phase_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .cmd_i        (cmd),
    .new_period_i (period_b),
    .elapsed_i    (item_i.elapsed_us),
    .trig_len_i   (trig_len_q),
    .trig_o       (result_o.trig_b),
    .gate_o       (result_o.gate_b)
  );

endmodule

FILE: hw/rtl/cmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock multiplier/divider checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
module cmd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  cmd_in_if.sink      in_mon,
  cmd_out_if.source   out_mon
);

  logic in_acc;
  assign in_acc = in_mon.valid && in_mon.ready;

  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_mon.valid |-> in_mon.ready)
    else $error("input stalled with empty result register");

  // every accepted sample yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_mon.valid)
    else $error("no result after accepted transaction");

  // beat only moves on an accepted sample
  a_beat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(out_mon.beat_flag))
    else $error("beat flag changed without a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mon.valid && !out_mon.ready |=> out_mon.valid)
    else $error("result dropped while stalled");

endmodule

bind clock_multiplier_divider_core cmd_checker u_cmd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_mon  (item_i),
  .out_mon (result_o)
);
